/* sv/shell_line_tokenizer_defines.svh */
// Assertion macros for the shell line tokenizer.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SHELL_LINE_TOKENIZER_DEFINES_SVH
`define SHELL_LINE_TOKENIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that an expression holds at every clock edge out of reset.
`define STL_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check that a condition implies an outcome in the following cycle.
`define STL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define STL_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define STL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* sv/stl_pkg.sv */
// Types, constants and character helpers for the shell line tokenizer.
// No dependencies; used by the output channel interface and the top level.
`default_nettype none

package stl_pkg;

  localparam int POS_BITS = 12;

  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_SQUOTE = 8'd39;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_PIPE   = 8'd124;
  localparam logic [7:0] CH_GT     = 8'd62;
  localparam logic [7:0] CH_LT     = 8'd60;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_CR     = 8'd13;

  localparam logic       KIND_TOKEN  = 1'b0;
  localparam logic       KIND_REPORT = 1'b1;

  localparam logic [1:0] Q_NONE   = 2'd0;
  localparam logic [1:0] Q_SINGLE = 2'd1;
  localparam logic [1:0] Q_DOUBLE = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SYNTAX = 2'd1;
  localparam logic [1:0] ST_LONG   = 2'd2;

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_WORD   = 5'b00010,
    MODE_QUOTED = 5'b00100,
    MODE_REDIR1 = 5'b01000,
    MODE_REDIR2 = 5'b10000
  } mode_t;

  typedef struct packed {
    logic                kind;
    logic [POS_BITS-1:0] token_start;
    logic [POS_BITS-1:0] token_end;
    logic [1:0]          quote_kind;
    logic [1:0]          status;
    logic                last;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Characters that close an unquoted word.
  function automatic logic is_sep(input logic [7:0] c);
    return is_space(c) || (c == CH_SQUOTE) || (c == CH_DQUOTE) || (c == CH_PIPE) ||
           (c == CH_GT) || (c == CH_LT);
  endfunction

endpackage

`default_nettype wire

/* sv/stl_channels.sv */
// Valid/ready channel interfaces for the shell line tokenizer.
// Depends on stl_pkg for the position width.
`default_nettype none

interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface stl_out_if import stl_pkg::*; ;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [POS_BITS-1:0] token_start;
  logic [POS_BITS-1:0] token_end;
  logic [1:0]          quote_kind;
  logic [1:0]          status;
  logic                last;

  modport source (output valid, output kind, output token_start, output token_end,
                  output quote_kind, output status, output last, input ready);
  modport sink   (input valid, input kind, input token_start, input token_end,
                  input quote_kind, input status, input last, output ready);
endinterface

`default_nettype wire

/* sv/shell_line_tokenizer.sv */
// Shell command line tokenizer, top level.
// Depends on stl_pkg, stl_channels and shell_line_tokenizer_defines.svh.
//
// Takes one byte of a command line per transfer on in_chan; a zero byte ends the line.
// Each byte lands in an input register, and once the queue has room a single pass of
// logic advances the tokenizer state and writes zero, one or two results into a
// four-entry result queue that drives out_chan. Tokens carry start and end positions
// (modulo 4096) and the quote kind; the zero byte adds an end-of-line report with the
// line status (ok, syntax error, line too long). A byte is taken every cycle while the
// queue has room for two more results, so the sustained rate is one byte per cycle,
// bounded by the output port's one result per cycle while out_chan is ready: a byte
// that yields two results needs an output transfer for each. A result passes through
// the input register and then the result queue on its way to out_chan.
`default_nettype none
`include "shell_line_tokenizer_defines.svh"

module shell_line_tokenizer
  import stl_pkg::*;
#(
  parameter int LINE_LEN = 4096
) (
  input  wire        clk,
  input  wire        rst_n,
  stl_in_if.sink     in_chan,
  stl_out_if.source  out_chan
);

  localparam int POS_W = $clog2(LINE_LEN + 1);
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input register
  logic       inv_r;
  logic [7:0] char_r;

  // Tokenizer state
  logic [POS_W-1:0]    pos_r, pos_nxt;
  mode_t               mode_r, mode_nxt;
  logic [POS_BITS-1:0] start_r, start_nxt;
  logic [1:0]          quote_r, quote_nxt;
  logic                redir_r, redir_nxt;
  logic [1:0]          status_r, status_nxt;

  // Result queue
  res_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] q_wr_r, q_rd_r;
  logic [QCNT_W-1:0] q_cnt_r;

  logic fire;
  logic pop;
  logic [1:0] n_push;

  // Position reduced to the 12-bit output field, whatever POS_W is.
  logic [POS_W+POS_BITS-1:0] pos_ext;
  logic [POS_BITS-1:0]       pos12;

  // Closing token (first) and pipe token or line report (second)
  logic close_v, second_v, do_begin, same_redir;
  res_t close_res, second_res, wr_a, wr_b;
  logic [1:0] final_status;
  logic [7:0] match_quote;

  assign pos_ext = {{POS_BITS{1'b0}}, pos_r};
  assign pos12   = pos_ext[POS_BITS-1:0];

  // Process a held byte only when the queue can take both possible results.
  assign fire = inv_r && (q_cnt_r <= QCNT_W'(QDEPTH - 2));
  assign in_chan.ready = !inv_r || fire;
  assign pop = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      inv_r <= 1'b1;
    end else if (fire) begin
      inv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      char_r <= in_chan.char_in;
    end
  end

  assign same_redir  = (char_r == (redir_r ? CH_LT : CH_GT));
  assign match_quote = (quote_r == Q_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

  always_comb begin
    pos_nxt    = pos_r;
    mode_nxt   = mode_r;
    start_nxt  = start_r;
    quote_nxt  = quote_r;
    redir_nxt  = redir_r;
    status_nxt = status_r;
    close_v    = 1'b0;
    second_v   = 1'b0;
    do_begin   = 1'b0;
    close_res  = '0;
    second_res = '0;
    final_status = status_r;
    close_res.kind  = KIND_TOKEN;
    second_res.kind = KIND_TOKEN;

    if (char_r == CH_NUL) begin
      // End of line: flush an open word or redirect token, report, then clear state.
      if (status_r != ST_LONG) begin
        unique case (mode_r)
          MODE_WORD: begin
            close_v = 1'b1;
            close_res.token_start = start_r;
            close_res.token_end   = pos12 - POS_BITS'(1);
          end
          MODE_REDIR1: begin
            close_v = 1'b1;
            close_res.token_start = start_r;
            close_res.token_end   = start_r;
          end
          MODE_REDIR2: begin
            close_v = 1'b1;
            close_res.token_start = start_r;
            close_res.token_end   = start_r + POS_BITS'(1);
          end
          MODE_QUOTED: begin
            // Drop the unclosed quoted token.
            if (status_r == ST_OK) begin
              final_status = ST_SYNTAX;
            end
          end
          default: ;
        endcase
      end
      second_v = 1'b1;
      second_res.kind   = KIND_REPORT;
      second_res.status = final_status;
      pos_nxt    = '0;
      mode_nxt   = MODE_IDLE;
      start_nxt  = '0;
      quote_nxt  = Q_NONE;
      redir_nxt  = 1'b0;
      status_nxt = ST_OK;
    end else if (status_r == ST_LONG) begin
      // Ignore the rest of an overlong line.
    end else if (pos_r >= POS_W'(LINE_LEN)) begin
      status_nxt = ST_LONG;
      mode_nxt   = MODE_IDLE;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
      unique case (mode_r)
        MODE_QUOTED: begin
          if (char_r == match_quote) begin
            close_v = 1'b1;
            close_res.token_start = start_r;
            close_res.token_end   = pos12 - POS_BITS'(1);
            close_res.quote_kind  = quote_r;
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_WORD: begin
          if (is_sep(char_r)) begin
            close_v = 1'b1;
            close_res.token_start = start_r;
            close_res.token_end   = pos12 - POS_BITS'(1);
            mode_nxt = MODE_IDLE;
            do_begin = 1'b1;
          end
        end
        MODE_REDIR1: begin
          if (same_redir) begin
            mode_nxt = MODE_REDIR2;
          end else begin
            close_v = 1'b1;
            close_res.token_start = start_r;
            close_res.token_end   = start_r;
            mode_nxt = MODE_IDLE;
            do_begin = 1'b1;
          end
        end
        MODE_REDIR2: begin
          if (same_redir) begin
            // Tripled redirect: flag it and slide the run by one.
            if (status_r == ST_OK) begin
              status_nxt = ST_SYNTAX;
            end
            start_nxt = start_r + POS_BITS'(1);
          end else begin
            close_v = 1'b1;
            close_res.token_start = start_r;
            close_res.token_end   = start_r + POS_BITS'(1);
            mode_nxt = MODE_IDLE;
            do_begin = 1'b1;
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          do_begin = 1'b1;
        end
      endcase

      // Open whatever the current byte starts.
      if (do_begin && !is_space(char_r)) begin
        if ((char_r == CH_SQUOTE) || (char_r == CH_DQUOTE)) begin
          mode_nxt  = MODE_QUOTED;
          quote_nxt = (char_r == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
          start_nxt = pos12 + POS_BITS'(1);
        end else if (char_r == CH_PIPE) begin
          second_v = 1'b1;
          second_res.token_start = pos12;
          second_res.token_end   = pos12;
        end else if ((char_r == CH_GT) || (char_r == CH_LT)) begin
          mode_nxt  = MODE_REDIR1;
          redir_nxt = (char_r == CH_LT);
          start_nxt = pos12;
        end else begin
          mode_nxt  = MODE_WORD;
          start_nxt = pos12;
        end
      end
    end

    close_res.last  = !second_v;
    second_res.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      mode_r   <= MODE_IDLE;
      start_r  <= '0;
      quote_r  <= Q_NONE;
      redir_r  <= 1'b0;
      status_r <= ST_OK;
    end else if (fire) begin
      pos_r    <= pos_nxt;
      mode_r   <= mode_nxt;
      start_r  <= start_nxt;
      quote_r  <= quote_nxt;
      redir_r  <= redir_nxt;
      status_r <= status_nxt;
    end
  end

  // Pack the results in order at the queue tail.
  assign wr_a   = close_v ? close_res : second_res;
  assign wr_b   = second_res;
  assign n_push = fire ? ({1'b0, close_v} + {1'b0, second_v}) : 2'd0;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_mem_r[q_wr_r] <= wr_a;
    end
    if (n_push == 2'd2) begin
      q_mem_r[q_wr_r + QPTR_W'(1)] <= wr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      q_wr_r  <= q_wr_r + QPTR_W'(n_push);
      q_rd_r  <= q_rd_r + QPTR_W'(pop);
      q_cnt_r <= q_cnt_r + QCNT_W'(n_push) - QCNT_W'(pop);
    end
  end

  assign out_chan.valid       = (q_cnt_r != '0);
  assign out_chan.kind        = q_mem_r[q_rd_r].kind;
  assign out_chan.token_start = q_mem_r[q_rd_r].token_start;
  assign out_chan.token_end   = q_mem_r[q_rd_r].token_end;
  assign out_chan.quote_kind  = q_mem_r[q_rd_r].quote_kind;
  assign out_chan.status      = q_mem_r[q_rd_r].status;
  assign out_chan.last        = q_mem_r[q_rd_r].last;

  // Checks
  `STL_ASSERT_ALWAYS(a_queue_bound, clk, rst_n, q_cnt_r <= QCNT_W'(QDEPTH), "result queue overflow")
  `STL_ASSERT_ALWAYS(a_pos_bound, clk, rst_n, pos_r <= POS_W'(LINE_LEN), "position past line length")
  `STL_ASSERT_NEXT(a_line_reset, clk, rst_n, fire && (char_r == CH_NUL), (mode_r == MODE_IDLE) && (pos_r == '0) && (status_r == ST_OK), "state not cleared after line end")
  `STL_ASSERT_NEXT(a_long_sticky, clk, rst_n, (status_r == ST_LONG) && !(fire && (char_r == CH_NUL)), status_r == ST_LONG, "overlong status lost before line end")

endmodule

`default_nettype wire
